// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expects a signal named clk, and SRU_ASSERT also rst, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define SRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define SRU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sru_pkg.sv =====
// Shared types, constants and widths of the sprite rectangle clip unit.
// Used by every module of the block and by its checker.
`timescale 1ns / 1ps

package sru_pkg;

  localparam int IN_DATA_W       = 240;
  localparam int OUT_DATA_W      = 104;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic signed [25:0] POS_MAX  = 26'sd8388607;
  localparam logic [16:0]        FRAC_ONE = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_CLIP_LEFT     = 3'd2,
    CFG_CLIP_TOP      = 3'd3,
    CFG_CLIP_EXTENT_X = 3'd4,
    CFG_CLIP_EXTENT_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic [22:0]        screen_width;
    logic [22:0]        screen_height;
    logic signed [23:0] clip_left;
    logic signed [23:0] clip_top;
    logic [22:0]        clip_extent_x;
    logic [22:0]        clip_extent_y;
  } sru_cfg_t;

  // Classified rectangle handed from the front to the back.
  typedef struct packed {
    logic               empty;
    logic signed [23:0] x0;
    logic signed [23:0] x1;
    logic signed [23:0] y0;
    logic signed [23:0] y1;
    logic [3:0][22:0]   cut;    // left, right, top, bottom
    logic [22:0]        rw;
    logic [22:0]        rh;
    logic signed [23:0] utl;
    logic signed [23:0] vtl;
    logic signed [24:0] du_x;
    logic signed [24:0] du_y;
    logic signed [24:0] dv_x;
    logic signed [24:0] dv_y;
  } sru_item_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic               visible;
    logic               last;
  } sru_result_t;

endpackage

// ===== design/sru_front.sv =====
// Front part: accepts a rectangle, clips it against the screen-limited window.
// Depends on sru_pkg.
`timescale 1ns / 1ps

module sru_front
  import sru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  sru_cfg_t             cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sru_item_t            out_item
);

  logic signed [25:0] rx, ry, x1, y1, cl, ct, xc, yc, xec, yec;
  logic signed [25:0] x0c, x1c, y0c, y1c, cut_l, cut_r, cut_t, cut_b;
  logic [22:0]        rw, rh;
  logic signed [23:0] utl, vtl, utr, vtr, ubl, vbl;
  sru_item_t          item_next;

  // Window limits and clipped edges.
  always_comb begin
    rx  = {{2{in_data[23]}}, in_data[23:0]};
    ry  = {{2{in_data[47]}}, in_data[47:24]};
    rw  = in_data[70:48];
    rh  = in_data[93:71];
    utl = in_data[117:94];
    vtl = in_data[141:118];
    utr = in_data[165:142];
    vtr = in_data[189:166];
    ubl = in_data[213:190];
    vbl = in_data[237:214];

    cl = {{2{cfg.clip_left[23]}}, cfg.clip_left};
    ct = {{2{cfg.clip_top[23]}}, cfg.clip_top};
    xc = (cl > 26'sd0) ? cl : 26'sd0;
    yc = (ct > 26'sd0) ? ct : 26'sd0;
    xec = cl + $signed({3'b000, cfg.clip_extent_x});
    yec = ct + $signed({3'b000, cfg.clip_extent_y});
    if (xec > POS_MAX) xec = POS_MAX;
    if (yec > POS_MAX) yec = POS_MAX;
    if (xec > $signed({3'b000, cfg.screen_width})) xec = $signed({3'b000, cfg.screen_width});
    if (yec > $signed({3'b000, cfg.screen_height})) yec = $signed({3'b000, cfg.screen_height});

    x1 = rx + $signed({3'b000, rw});
    y1 = ry + $signed({3'b000, rh});

    x0c   = (rx < xc) ? xc : rx;
    cut_l = (rx < xc) ? (xc - rx) : 26'sd0;
    x1c   = (x1 > xec) ? xec : x1;
    cut_r = (x1 > xec) ? (x1 - xec) : 26'sd0;
    y0c   = (ry < yc) ? yc : ry;
    cut_t = (ry < yc) ? (yc - ry) : 26'sd0;
    y1c   = (y1 > yec) ? yec : y1;
    cut_b = (y1 > yec) ? (y1 - yec) : 26'sd0;

    item_next.empty = (rw == 23'd0) || (rh == 23'd0) || (x0c >= x1c) || (y0c >= y1c);
    item_next.x0    = x0c[23:0];
    item_next.x1    = x1c[23:0];
    item_next.y0    = y0c[23:0];
    item_next.y1    = y1c[23:0];
    item_next.cut[0] = cut_l[22:0];
    item_next.cut[1] = cut_r[22:0];
    item_next.cut[2] = cut_t[22:0];
    item_next.cut[3] = cut_b[22:0];
    item_next.rw    = rw;
    item_next.rh    = rh;
    item_next.utl   = utl;
    item_next.vtl   = vtl;
    item_next.du_x  = {utr[23], utr} - {utl[23], utl};
    item_next.du_y  = {ubl[23], ubl} - {utl[23], utl};
    item_next.dv_x  = {vtr[23], vtr} - {vtl[23], vtl};
    item_next.dv_y  = {vbl[23], vbl} - {vtl[23], vtl};
  end

  assign in_ready = !out_valid || out_ready;

  // Output register of the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== design/sru_queue.sv =====
// Short queue between the front and the back of the clip unit.
// Depends on sru_pkg.
`timescale 1ns / 1ps

module sru_queue
  import sru_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sru_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output sru_item_t out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sru_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== design/sru_back.sv =====
// Back part: divides the cuts into fractions, interpolates texture coordinates
// and emits the four corners. Depends on sru_pkg.
`timescale 1ns / 1ps

module sru_back
  import sru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sru_item_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output sru_result_t out_result
);

  // Four restoring division steps on one quotient.
  function automatic logic [38:0] div4(input logic [22:0] r, input logic [22:0] d,
                                       input logic [15:0] q);
    logic [23:0] t;
    logic [22:0] rr;
    logic [15:0] qq;
    rr = r;
    qq = q;
    for (int i = 0; i < 4; i++) begin
      t = {rr, 1'b0};
      if (t >= {1'b0, d}) begin
        t  = t - {1'b0, d};
        qq = {qq[14:0], 1'b1};
      end else begin
        qq = {qq[14:0], 1'b0};
      end
      rr = t[22:0];
    end
    return {rr, qq};
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] s);
    if (s > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -28'sd8388608) begin
      return 24'sh800000;
    end
    return s[23:0];
  endfunction

  // Divider stage.
  logic             dv;
  logic [2:0]       dcnt;
  sru_item_t        ditem;
  logic [3:0][22:0] rem;
  logic [3:0][15:0] qt;
  logic [3:0][22:0] rem_next;
  logic [3:0][15:0] qt_next;
  logic             ddone, load, transfer;

  // Emit stage.
  logic               ev;
  logic [1:0]         ek;
  sru_item_t          eitem;
  logic [16:0]        fx0, fx1, fy0, fy1;
  logic               elast, emit_take, issue, en;
  logic [16:0]        fx, fy;

  // Multiply stage.
  logic               mv, mvis, mlast;
  logic [1:0]         mcorner;
  logic signed [23:0] mx, my, mutl, mvtl;
  logic signed [42:0] pu_a, pu_b, pv_a, pv_b;
  logic signed [27:0] sum_u, sum_v;

  assign ddone     = dv && (dcnt == 3'd4);
  assign elast     = eitem.empty || (ek == CORNER_BL);
  assign en        = !out_valid || out_ready;
  assign issue     = ev && en;
  assign emit_take = !ev || (issue && elast);
  assign transfer  = ddone && emit_take;
  assign load      = in_valid && (!dv || transfer);
  assign in_ready  = load;

  // Next divider values, from the queue head on a load.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (load) begin
        {rem_next[k], qt_next[k]} = div4(in_item.cut[k], (k < 2) ? in_item.rw : in_item.rh,
                                         16'd0);
      end else begin
        {rem_next[k], qt_next[k]} = div4(rem[k], (k < 2) ? ditem.rw : ditem.rh, qt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else if (load) begin
      dv <= 1'b1;
    end else if (transfer) begin
      dv <= 1'b0;
    end
    if (load) begin
      ditem <= in_item;
      dcnt  <= 3'd1;
      rem   <= rem_next;
      qt    <= qt_next;
    end else if (dv && !ddone) begin
      dcnt <= dcnt + 3'd1;
      rem  <= rem_next;
      qt   <= qt_next;
    end
  end

  // Emit stage: takes finished fractions, walks the corners.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else if (emit_take) begin
      ev <= transfer;
    end
    if (transfer) begin
      eitem <= ditem;
      ek    <= CORNER_TL;
      fx0   <= {1'b0, qt[0]};
      fx1   <= FRAC_ONE - {1'b0, qt[1]};
      fy0   <= {1'b0, qt[2]};
      fy1   <= FRAC_ONE - {1'b0, qt[3]};
    end else if (issue) begin
      ek <= ek + 2'd1;
    end
  end

  assign fx = ((ek == CORNER_TL) || (ek == CORNER_BL)) ? fx0 : fx1;
  assign fy = ((ek == CORNER_TL) || (ek == CORNER_TR)) ? fy0 : fy1;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= ev;
    end
    if (issue) begin
      mcorner <= ek;
      mx      <= ((ek == CORNER_TL) || (ek == CORNER_BL)) ? eitem.x0 : eitem.x1;
      my      <= ((ek == CORNER_TL) || (ek == CORNER_TR)) ? eitem.y0 : eitem.y1;
      mvis    <= !eitem.empty;
      mlast   <= elast;
      mutl    <= eitem.utl;
      mvtl    <= eitem.vtl;
      pu_a    <= $signed({1'b0, fx}) * eitem.du_x;
      pu_b    <= $signed({1'b0, fy}) * eitem.du_y;
      pv_a    <= $signed({1'b0, fx}) * eitem.dv_x;
      pv_b    <= $signed({1'b0, fy}) * eitem.dv_y;
    end
  end

  // Sum with floor shift, then saturate.
  assign sum_u = {{4{mutl[23]}}, mutl} + {pu_a[42], pu_a[42:16]} + {pu_b[42], pu_b[42:16]};
  assign sum_v = {{4{mvtl[23]}}, mvtl} + {pv_a[42], pv_a[42:16]} + {pv_b[42], pv_b[42:16]};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mv;
    end
    if (en && mv) begin
      out_result.visible <= mvis;
      out_result.last    <= mlast;
      if (mvis) begin
        out_result.corner <= mcorner;
        out_result.pos_x  <= mx;
        out_result.pos_y  <= my;
        out_result.tex_u  <= sat24(sum_u);
        out_result.tex_v  <= sat24(sum_v);
      end else begin
        out_result.corner <= CORNER_TL;
        out_result.pos_x  <= '0;
        out_result.pos_y  <= '0;
        out_result.tex_u  <= '0;
        out_result.tex_v  <= '0;
      end
    end
  end

endmodule

// ===== design/sprite_rect_clip_uv_unit.sv =====
// Top level of the sprite rectangle clip unit: configuration registers,
// front, queue and back. Depends on sru_pkg, sru_front, sru_queue, sru_back.
//
// Usage: a rectangle request enters on the s_axis channel; each request gives
// four corner results on m_axis (top-left, top-right, bottom-right,
// bottom-left, tlast on the fourth), or one result with tuser low and tlast
// high when nothing of the rectangle is left after clipping.
// The clip window and screen size are written through cfg_we, cfg_index and
// cfg_wdata while the unit is idle; indexes past the last register are ignored.
// The four cut fractions are divided in parallel at four quotient bits a cycle,
// and the output channel moves one corner a cycle while the receiver is ready;
// the divider takes the next request while the corners of the last are emitted.
// A queue between the clipping front and the dividing back lets the front
// keep taking requests while the back waits on a stalled receiver.
// Reset clears all valid state and loads the default 640x480 window.
`timescale 1ns / 1ps

module sprite_rect_clip_uv_unit
  import sru_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // rect_left, rect_top, rect_width, rect_height, u_top_left, v_top_left,
  // u_top_right, v_top_right, u_bottom_left, v_bottom_left, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // corner, pos_x, pos_y, tex_u, tex_v, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // visible
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sru_cfg_t    cfg;
  sru_item_t   f_item, q_item;
  sru_result_t res;
  logic        f_valid, f_ready, q_valid, q_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 23'd163840;
      cfg.screen_height <= 23'd122880;
      cfg.clip_left     <= '0;
      cfg.clip_top      <= '0;
      cfg.clip_extent_x <= 23'd163840;
      cfg.clip_extent_y <= 23'd122880;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_wdata[22:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_wdata[22:0];
        CFG_CLIP_LEFT:     cfg.clip_left     <= cfg_wdata;
        CFG_CLIP_TOP:      cfg.clip_top      <= cfg_wdata;
        CFG_CLIP_EXTENT_X: cfg.clip_extent_x <= cfg_wdata[22:0];
        CFG_CLIP_EXTENT_Y: cfg.clip_extent_y <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  sru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  sru_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  sru_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res)
  );

  // Result packing.
  assign m_axis_tdata = {6'd0, res.tex_v, res.tex_u, res.pos_y, res.pos_x, res.corner};
  assign m_axis_tuser = res.visible;
  assign m_axis_tlast = res.last;

endmodule

// ===== design/sru_checker.sv =====
// Port-level checks of the sprite rectangle clip unit, bound to its top level.
// Depends on sru_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sru_checker
  import sru_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // No result may be offered right after a reset cycle.
  `SRU_ASSERT_RST(a_reset_quiet, rst |=> !m_axis_tvalid, "result valid after reset")

  // A stalled result holds.
  `SRU_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // A clipped-away rectangle is a single zeroed result.
  `SRU_ASSERT(a_empty_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "empty result not zero or not last")

  // Only the bottom-left corner closes a visible quad.
  `SRU_ASSERT(a_last_corner, m_axis_tvalid && m_axis_tuser |-> (m_axis_tlast == (m_axis_tdata[1:0] == CORNER_BL)), "last flag on wrong corner")

endmodule

bind sprite_rect_clip_uv_unit sru_checker u_sru_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb.sv =====
// Self-checking bench for sprite_rect_clip_uv_unit: drives rectangle requests,
// predicts the clipped corners and texture coordinates, and checks each corner.
// Depends on sru_pkg and the unit under test.
`timescale 1ns / 1ps

module tb;
  import sru_pkg::*;

  // Rectangle request fields as they travel on s_axis.
  typedef struct {
    logic signed [23:0] left, top;
    logic [22:0]        w, h;
    logic signed [23:0] utl, vtl, utr, vtr, ubl, vbl;
  } rect_req_t;

  // Predicted corners of each accepted rectangle, checked in order.
  class corner_board;
    sru_result_t pending[$];
    int          errors;
    logic [22:0] scr_w, scr_h, ext_x, ext_y;
    logic signed [23:0] clip_l, clip_t;

    function new();
      errors = 0;
      scr_w = 23'd163840; scr_h = 23'd122880;
      clip_l = '0; clip_t = '0;
      ext_x = 23'd163840; ext_y = 23'd122880;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] val);
      case (idx)
        CFG_SCREEN_WIDTH:  scr_w = val[22:0];
        CFG_SCREEN_HEIGHT: scr_h = val[22:0];
        CFG_CLIP_LEFT:     clip_l = val;
        CFG_CLIP_TOP:      clip_t = val;
        CFG_CLIP_EXTENT_X: ext_x = val[22:0];
        CFG_CLIP_EXTENT_Y: ext_y = val[22:0];
        default: ;
      endcase
    endfunction

    // Floor of x / 65536 for signed values.
    function longint floor16(longint x);
      return x >>> 16;
    endfunction

    function logic [23:0] lerp_tex(longint ctl, longint ctr, longint cbl,
                                   longint fx, longint fy);
      longint r;
      r = ctl + floor16(fx * (ctr - ctl)) + floor16(fy * (cbl - ctl));
      if (r < -8388608) r = -8388608;
      if (r > 8388607) r = 8388607;
      return r[23:0];
    endfunction

    function sru_result_t mk(corner_t c, longint x, longint y, longint fx,
                             longint fy, rect_req_t q, logic lst);
      sru_result_t r;
      r.corner = c;
      r.pos_x = x[23:0];
      r.pos_y = y[23:0];
      r.tex_u = lerp_tex(q.utl, q.utr, q.ubl, fx, fy);
      r.tex_v = lerp_tex(q.vtl, q.vtr, q.vbl, fx, fy);
      r.visible = 1'b1;
      r.last = lst;
      return r;
    endfunction

    function void note_rect(rect_req_t q);
      longint xc, yc, xe, ye, x0, x1, y0, y1, fx0, fx1, fy0, fy1, rw, rh;
      sru_result_t e;
      rw = longint'(q.w); rh = longint'(q.h);
      xc = (clip_l > 0) ? longint'(clip_l) : 0;
      yc = (clip_t > 0) ? longint'(clip_t) : 0;
      xe = longint'(clip_l) + longint'(ext_x);
      ye = longint'(clip_t) + longint'(ext_y);
      if (xe > 8388607) xe = 8388607;
      if (ye > 8388607) ye = 8388607;
      if (xe > longint'(scr_w)) xe = longint'(scr_w);
      if (ye > longint'(scr_h)) ye = longint'(scr_h);
      x0 = q.left; x1 = x0 + rw; y0 = q.top; y1 = y0 + rh;
      fx0 = 0; fx1 = 65536; fy0 = 0; fy1 = 65536;
      e = '0;
      e.last = 1'b1;
      if (rw == 0 || rh == 0) begin
        pending.push_back(e);
        return;
      end
      if (x0 < xc) begin fx0 = ((xc - x0) * 65536) / rw; x0 = xc; end
      if (x1 > xe) begin fx1 = 65536 - ((x1 - xe) * 65536) / rw; x1 = xe; end
      if (y0 < yc) begin fy0 = ((yc - y0) * 65536) / rh; y0 = yc; end
      if (y1 > ye) begin fy1 = 65536 - ((y1 - ye) * 65536) / rh; y1 = ye; end
      if (x0 >= x1 || y0 >= y1) begin
        pending.push_back(e);
        return;
      end
      pending.push_back(mk(CORNER_TL, x0, y0, fx0, fy0, q, 1'b0));
      pending.push_back(mk(CORNER_TR, x1, y0, fx1, fy0, q, 1'b0));
      pending.push_back(mk(CORNER_BR, x1, y1, fx1, fy1, q, 1'b0));
      pending.push_back(mk(CORNER_BL, x0, y1, fx0, fy1, q, 1'b1));
    endfunction

    function void check_corner(sru_result_t got);
      sru_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected corner %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.corner !== e.corner || got.pos_x !== e.pos_x ||
          got.pos_y !== e.pos_y || got.tex_u !== e.tex_u ||
          got.tex_v !== e.tex_v || got.visible !== e.visible ||
          got.last !== e.last) begin
        $display("%0t: corner mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  corner_board board;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;
  bit done;

  sprite_rect_clip_uv_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each accepted corner.
  always @(posedge clk) begin
    sru_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.corner = m_axis_tdata[1:0];
      got.pos_x = m_axis_tdata[25:2];
      got.pos_y = m_axis_tdata[49:26];
      got.tex_u = m_axis_tdata[73:50];
      got.tex_v = m_axis_tdata[97:74];
      got.visible = m_axis_tuser;
      got.last = m_axis_tlast;
      board.check_corner(got);
    end
  end

  // Watchdog on cycles with no accepted transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drive one rectangle request and wait for it to be taken.
  task automatic send_rect(rect_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'd0, q.vbl, q.ubl, q.vtr, q.utr, q.vtl, q.utl,
                     q.h, q.w, q.top, q.left};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_rect(q);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [23:0] rnd24();
    return 24'($urandom());
  endfunction

  // Mostly rectangles near the clip window, some fully random.
  function automatic rect_req_t rnd_rect();
    rect_req_t q;
    q.utl = rnd24(); q.vtl = rnd24(); q.utr = rnd24();
    q.vtr = rnd24(); q.ubl = rnd24(); q.vbl = rnd24();
    if ($urandom_range(9) < 2) begin
      q.left = rnd24(); q.top = rnd24();
      q.w = 23'($urandom()); q.h = 23'($urandom());
    end else begin
      q.left = 24'($signed($urandom_range(200000)) - 40000);
      q.top = 24'($signed($urandom_range(160000)) - 30000);
      q.w = 23'($urandom_range(60000, 1));
      q.h = 23'($urandom_range(60000, 1));
      if ($urandom_range(19) == 0) q.w = '0;
    end
    return q;
  endfunction

  function automatic rect_req_t mk_rect(int l, int t, int w, int h,
                                        logic [23:0] a, logic [23:0] b);
    rect_req_t q;
    q.left = 24'(l); q.top = 24'(t); q.w = 23'(w); q.h = 23'(h);
    q.utl = a; q.vtl = b; q.utr = b; q.vtr = a; q.ubl = ~a; q.vbl = ~b;
    return q;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_rect(rnd_rect());
    drain();
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 21;
    recv_idle_pct = 52;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: inside, edge cuts, zero sizes, extremes, texture saturation.
    send_rect(mk_rect(1000, 2000, 5000, 6000, 24'h000000, 24'h010000));
    send_rect(mk_rect(-5000, -5000, 20000, 20000, 24'h7FFFFF, 24'h800000));
    send_rect(mk_rect(150000, 110000, 30000, 30000, 24'h800000, 24'h7FFFFF));
    send_rect(mk_rect(-8388608, -8388608, 8388607, 8388607, 24'h7FFFFF, 24'h800000));
    send_rect(mk_rect(8388607, 8388607, 8388607, 8388607, 24'h123456, 24'hFEDCBA));
    send_rect(mk_rect(100, 100, 0, 500, 24'h1, 24'h2));
    send_rect(mk_rect(100, 100, 500, 0, 24'h1, 24'h2));
    send_rect(mk_rect(-1000, 0, 1000, 1000, 24'h1, 24'h2));
    send_rect(mk_rect(-300000, -300000, 8388607, 8388607, 24'hFFFFFF, 24'h555555));
    send_rect(mk_rect(163839, 122879, 1, 1, 24'hAAAAAA, 24'h555555));
    drain();

    // Odd window, then an empty window, then one with saturating extents, then a zero screen width.
    write_reg(CFG_CLIP_LEFT, -24'sd5000);
    write_reg(CFG_CLIP_TOP, 24'd3000);
    write_reg(CFG_CLIP_EXTENT_X, 24'd100000);
    write_reg(CFG_CLIP_EXTENT_Y, 24'd50000);
    random_phase(40);
    write_reg(CFG_CLIP_EXTENT_X, 24'd0);
    send_rect(mk_rect(1000, 4000, 5000, 6000, 24'h1, 24'h2));
    drain();
    write_reg(CFG_SCREEN_WIDTH, 24'h7FFFFF);
    write_reg(CFG_SCREEN_HEIGHT, 24'h7FFFFF);
    write_reg(CFG_CLIP_LEFT, 24'h7FFFFF);
    write_reg(CFG_CLIP_TOP, 24'h800000);
    write_reg(CFG_CLIP_EXTENT_X, 24'h7FFFFF);
    write_reg(CFG_CLIP_EXTENT_Y, 24'h7FFFFF);
    send_rect(mk_rect(8388000, -100, 600, 400, 24'h3, 24'h4));
    drain();
    write_reg(CFG_CLIP_LEFT, 24'd0);
    write_reg(CFG_CLIP_TOP, 24'd0);
    write_reg(CFG_SCREEN_WIDTH, 24'd0);
    send_rect(mk_rect(0, 0, 500, 500, 24'h3, 24'h4));
    drain();
    write_reg(CFG_SCREEN_WIDTH, 24'd163840);
    write_reg(CFG_SCREEN_HEIGHT, 24'd122880);
    write_reg(CFG_CLIP_EXTENT_X, 24'd163840);
    write_reg(CFG_CLIP_EXTENT_Y, 24'd122880);

    // Long receiver hold-off while requests keep coming.
    send_idle_pct = 0;
    hold_cycles = 300;
    random_phase(30);

    send_idle_pct = 52;
    recv_idle_pct = 21;
    random_phase(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(70);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
